// ===== hw/rtl/i2cms_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, codes and address helpers for the I2C master event sequencer.
// No dependencies; every other source file but i2cms_if imports this package.
package i2cms_pkg;

  typedef enum logic [1:0] {
    MODE_IDLE = 2'd0,
    MODE_TX   = 2'd1,
    MODE_RX   = 2'd2
  } mode_t;

  typedef enum logic [1:0] {
    OP_START_WR = 2'd0,
    OP_START_RD = 2'd1,
    OP_BUS_EVT  = 2'd2,
    OP_ERR_EVT  = 2'd3
  } opcode_t;

  localparam logic [2:0] ERR_BUS      = 3'd0;
  localparam logic [2:0] ERR_ACK_FAIL = 3'd1;
  localparam logic [2:0] ERR_OVERRUN  = 3'd2;
  localparam logic [2:0] ERR_TIMEOUT  = 3'd3;
  localparam logic [2:0] ERR_NONE     = 3'd4;

  // event flag bit positions
  localparam int FLAG_START    = 0;
  localparam int FLAG_ADDR     = 1;
  localparam int FLAG_HEADER   = 3;
  localparam int FLAG_RX_FULL  = 6;
  localparam int FLAG_TX_EMPTY = 7;
  localparam int FLAG_BUS_ERR  = 8;
  localparam int FLAG_ACK_FAIL = 10;
  localparam int FLAG_OVERRUN  = 11;
  localparam int FLAG_TIMEOUT  = 14;

  localparam logic REG_TEN_BIT     = 1'b0;
  localparam logic REG_TARGET_ADDR = 1'b1;

  localparam logic [7:0] HEADER_BASE = 8'hF0;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [7:0]  byte_count;
    logic [15:0] event_flags;
    logic [7:0]  tx_byte;
    logic [7:0]  rx_byte;
  } item_t;

  typedef struct packed {
    logic       rejected;
    logic       dr_write;
    logic [7:0] dr_value;
    logic       start_req;
    logic       stop_req;
    logic       ack_enable;
    logic       bus_enable;
    logic       tx_taken;
    logic       rx_valid;
    logic [7:0] rx_data;
    logic [1:0] mode_now;
    logic [2:0] fault_code;
  } result_t;

  typedef struct packed {
    logic       ten_bit_mode;
    logic [9:0] target_address;
  } cfg_t;

  // 10-bit header: 11110 A9 A8 R/W
  function automatic logic [7:0] header_byte(logic [9:0] addr, logic rw);
    header_byte = HEADER_BASE | {5'd0, addr[9:8], rw};
  endfunction

  function automatic logic [7:0] first_address_byte(logic ten_bit, logic [9:0] addr,
                                                    logic rw);
    if (ten_bit) begin
      first_address_byte = header_byte(addr, 1'b0);
    end else begin
      first_address_byte = {addr[6:0], rw};
    end
  endfunction

endpackage

// ===== hw/rtl/i2cms_if.sv =====
`timescale 1ns / 1ps
// Valid/ready channel interfaces: event items in, results out, register writes.
// Imports nothing; its widths are kept in step with i2cms_pkg by hand.
interface i2cms_item_if;
  logic        valid;
  logic        ready;
  logic [1:0]  opcode;
  logic [7:0]  byte_count;
  logic [15:0] event_flags;
  logic [7:0]  tx_byte;
  logic [7:0]  rx_byte;
  modport source (output valid, opcode, byte_count, event_flags, tx_byte, rx_byte,
                  input ready);
  modport sink (input valid, opcode, byte_count, event_flags, tx_byte, rx_byte,
                output ready);
endinterface

interface i2cms_result_if;
  logic       valid;
  logic       ready;
  logic       rejected;
  logic       dr_write;
  logic [7:0] dr_value;
  logic       start_req;
  logic       stop_req;
  logic       ack_enable;
  logic       bus_enable;
  logic       tx_taken;
  logic       rx_valid;
  logic [7:0] rx_data;
  logic [1:0] mode_now;
  logic [2:0] fault_code;
  modport source (output valid, rejected, dr_write, dr_value, start_req, stop_req,
                  ack_enable, bus_enable, tx_taken, rx_valid, rx_data, mode_now,
                  fault_code, input ready);
  modport sink (input valid, rejected, dr_write, dr_value, start_req, stop_req,
                ack_enable, bus_enable, tx_taken, rx_valid, rx_data, mode_now,
                fault_code, output ready);
endinterface

interface i2cms_cfg_if;
  logic       valid;
  logic       ready;
  logic       index;
  logic [9:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== hw/rtl/i2cms_cfg_regs.sv =====
`timescale 1ns / 1ps
// Configuration registers: addressing mode and target address.
// Depends on i2cms_pkg and i2cms_cfg_if.
module i2cms_cfg_regs
  import i2cms_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  i2cms_cfg_if.sink   cfg,
  output cfg_t        cfg_q
);

  logic       ten_bit_mode;
  logic [9:0] target_address;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      ten_bit_mode   <= 1'b0;
      target_address <= '0;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_TEN_BIT:     ten_bit_mode   <= cfg.data[0];
        REG_TARGET_ADDR: target_address <= cfg.data;
        default: ;
      endcase
    end
  end

  assign cfg_q = '{ten_bit_mode: ten_bit_mode, target_address: target_address};

endmodule

// ===== hw/rtl/i2cms_seq_core.sv =====
`timescale 1ns / 1ps
// Transaction state and per-item decode: one item per step, result is combinational.
// Depends on i2cms_pkg.
module i2cms_seq_core
  import i2cms_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    step,
  input  item_t   item,
  input  cfg_t    cfg_q,
  output result_t res
);

  mode_t      mode, mode_next;
  logic [7:0] remaining, remaining_next;
  logic       restart_done, restart_done_next;
  logic       ack_level, ack_level_next;
  logic       enable_level, enable_level_next;
  logic [7:0] rem_dec;

  assign rem_dec = remaining - 8'd1;

  always_comb begin
    mode_next         = mode;
    remaining_next    = remaining;
    restart_done_next = restart_done;
    ack_level_next    = ack_level;
    enable_level_next = enable_level;
    res               = '0;
    res.fault_code    = ERR_NONE;

    case (opcode_t'(item.opcode))
      OP_START_WR, OP_START_RD: begin
        if (mode != MODE_IDLE) begin
          res.rejected = 1'b1;
        end else begin
          enable_level_next = 1'b1;
          res.start_req     = 1'b1;
          remaining_next    = item.byte_count;
          restart_done_next = 1'b0;
          if (opcode_t'(item.opcode) == OP_START_WR) begin
            mode_next = MODE_TX;
          end else begin
            mode_next      = MODE_RX;
            ack_level_next = 1'b1;
          end
        end
      end
      OP_BUS_EVT: begin
        case (mode)
          MODE_TX: begin
            if (item.event_flags[FLAG_START]) begin
              res.dr_write = 1'b1;
              res.dr_value = first_address_byte(cfg_q.ten_bit_mode,
                                                cfg_q.target_address, 1'b0);
            end else if (item.event_flags[FLAG_HEADER]) begin
              res.dr_write = 1'b1;
              res.dr_value = cfg_q.target_address[7:0];
            end else if (item.event_flags[FLAG_ADDR]) begin
              // address phase done, wait for tx empty
            end else if (item.event_flags[FLAG_TX_EMPTY]) begin
              if (remaining == '0) begin
                res.stop_req      = 1'b1;
                enable_level_next = 1'b0;
                mode_next         = MODE_IDLE;
              end else begin
                remaining_next = rem_dec;
                res.dr_write   = 1'b1;
                res.dr_value   = item.tx_byte;
                res.tx_taken   = 1'b1;
              end
            end
          end
          MODE_RX: begin
            if (item.event_flags[FLAG_START]) begin
              res.dr_write = 1'b1;
              res.dr_value = restart_done
                ? header_byte(cfg_q.target_address, 1'b1)
                : first_address_byte(cfg_q.ten_bit_mode, cfg_q.target_address, 1'b1);
            end else if (item.event_flags[FLAG_HEADER]) begin
              res.dr_write = 1'b1;
              res.dr_value = cfg_q.target_address[7:0];
            end else if (item.event_flags[FLAG_ADDR]) begin
              // 10-bit read turns the bus around with a repeated start
              if (!restart_done && cfg_q.ten_bit_mode) begin
                res.start_req     = 1'b1;
                restart_done_next = 1'b1;
              end else if (remaining == 8'd1) begin
                ack_level_next = 1'b0;
              end
            end else if (item.event_flags[FLAG_RX_FULL]) begin
              res.rx_valid   = 1'b1;
              res.rx_data    = item.rx_byte;
              remaining_next = rem_dec;
              if (rem_dec < 8'd2) begin
                ack_level_next    = 1'b0;
                res.stop_req      = 1'b1;
                restart_done_next = 1'b0;
                mode_next         = MODE_IDLE;
                enable_level_next = 1'b0;
              end
            end
          end
          default: ;
        endcase
      end
      default: begin
        if (item.event_flags[FLAG_BUS_ERR]) begin
          res.fault_code = ERR_BUS;
        end else if (item.event_flags[FLAG_ACK_FAIL]) begin
          res.fault_code = ERR_ACK_FAIL;
        end else if (item.event_flags[FLAG_OVERRUN]) begin
          res.fault_code = ERR_OVERRUN;
        end else if (item.event_flags[FLAG_TIMEOUT]) begin
          res.fault_code = ERR_TIMEOUT;
        end
        enable_level_next = 1'b0;
        mode_next         = MODE_IDLE;
        restart_done_next = 1'b0;
      end
    endcase

    res.ack_enable = ack_level_next;
    res.bus_enable = enable_level_next;
    res.mode_now   = mode_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode         <= MODE_IDLE;
      remaining    <= '0;
      restart_done <= 1'b0;
      ack_level    <= 1'b0;
      enable_level <= 1'b0;
    end else if (step) begin
      mode         <= mode_next;
      remaining    <= remaining_next;
      restart_done <= restart_done_next;
      ack_level    <= ack_level_next;
      enable_level <= enable_level_next;
    end
  end

  // bus enable tracks an open transaction
  a_enable_matches_mode: assert property (@(posedge clk) disable iff (rst)
    (mode == MODE_IDLE) == !enable_level)
    else $error("enable level out of step with mode");

  a_error_forces_idle: assert property (@(posedge clk) disable iff (rst)
    step && opcode_t'(item.opcode) == OP_ERR_EVT |=> mode == MODE_IDLE && !restart_done)
    else $error("error event did not force idle");

  a_reject_keeps_state: assert property (@(posedge clk) disable iff (rst)
    step && res.rejected |=> $stable(mode) && $stable(remaining) && $stable(ack_level))
    else $error("rejected start changed state");

  a_restart_only_rx: assert property (@(posedge clk) disable iff (rst)
    restart_done |-> mode == MODE_RX)
    else $error("restart flag set outside a read");

endmodule

// ===== hw/rtl/i2c_master_event_sequencer.sv =====
`timescale 1ns / 1ps
// I2C master event sequencer top level: input register, decode core, result register.
// An accepted item is held in the input register, decoded, and its result registered in the result register.
// Throughput: one item per cycle while results are taken; the input register and result
// register form a two-deep pipeline, and a stalled result closes input once s1 is full.
// Reset (rst, synchronous): mode idle, counters, levels and config cleared, no results.
// Depends on i2cms_pkg, i2cms_if, i2cms_cfg_regs and i2cms_seq_core.
module i2c_master_event_sequencer
  import i2cms_pkg::*;
(
  input  logic           clk,
  input  logic           rst,
  i2cms_item_if.sink     item,
  i2cms_result_if.source result,
  i2cms_cfg_if.sink      cfg
);

  cfg_t    cfg_q;
  item_t   s1_item;
  logic    s1_valid;
  logic    s1_ready;
  logic    advance;
  logic    step;
  result_t res;
  result_t res_reg;
  logic    res_valid;

  i2cms_cfg_regs u_cfg (
    .clk   (clk),
    .rst   (rst),
    .cfg   (cfg),
    .cfg_q (cfg_q)
  );

  i2cms_seq_core u_core (
    .clk   (clk),
    .rst   (rst),
    .step  (step),
    .item  (s1_item),
    .cfg_q (cfg_q),
    .res   (res)
  );

  // result register free, or being drained this cycle
  assign advance    = !res_valid || result.ready;
  assign step       = s1_valid && advance;
  assign s1_ready   = !s1_valid || advance;
  assign item.ready = s1_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      if (s1_ready) begin
        s1_valid <= item.valid;
      end
      if (advance) begin
        res_valid <= s1_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (item.valid && s1_ready) begin
      s1_item <= '{opcode: item.opcode, byte_count: item.byte_count,
                   event_flags: item.event_flags, tx_byte: item.tx_byte,
                   rx_byte: item.rx_byte};
    end
    if (step) begin
      res_reg <= res;
    end
  end

  assign result.valid      = res_valid;
  assign result.rejected   = res_reg.rejected;
  assign result.dr_write   = res_reg.dr_write;
  assign result.dr_value   = res_reg.dr_value;
  assign result.start_req  = res_reg.start_req;
  assign result.stop_req   = res_reg.stop_req;
  assign result.ack_enable = res_reg.ack_enable;
  assign result.bus_enable = res_reg.bus_enable;
  assign result.tx_taken   = res_reg.tx_taken;
  assign result.rx_valid   = res_reg.rx_valid;
  assign result.rx_data    = res_reg.rx_data;
  assign result.mode_now   = res_reg.mode_now;
  assign result.fault_code = res_reg.fault_code;

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for i2c_master_event_sequencer: directed cases, phased random
// I2C transactions with noise, back-to-back runs. Depends on i2cms_pkg, i2cms_if, RTL top.
module tb;
  import i2cms_pkg::*;

  localparam int STALL_NONE     = 0;
  localparam int STALL_RANDOM   = 1;
  localparam int STALL_PERIODIC = 2;
  localparam int STALL_HEAVY    = 3;

  logic clk;
  logic rst;

  i2cms_item_if   item_ch ();
  i2cms_result_if res_ch ();
  i2cms_cfg_if    cfg_ch ();

  i2c_master_event_sequencer u_top (
    .clk    (clk),
    .rst    (rst),
    .item   (item_ch),
    .result (res_ch),
    .cfg    (cfg_ch)
  );

  // predictor state
  mode_t      seq_mode;
  logic [7:0] bytes_left;
  logic       restarted;
  logic       ack_lvl;
  logic       en_lvl;
  logic       cfg_ten_bit;
  logic [9:0] cfg_addr;

  result_t    pending_results[$];

  int error_count;
  int results_seen;
  int items_sent;
  int n_rejected, n_tx_bytes, n_rx_bytes, n_err_events, n_stops;

  // sender / receiver pacing
  bit gaps_enabled;
  int burst_left;
  int stall_style;
  int stall_left;
  int stall_phase;

  // stimulus-side copy of the addressing mode
  logic stim_ten_bit;

  initial begin
    clk = 1'b0;
  end

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #(5_000_000);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------
  function automatic logic [7:0] ten_bit_header(logic rw);
    return {5'b11110, cfg_addr[9:8], rw};
  endfunction

  function automatic logic [7:0] leading_address(logic rw);
    // 10-bit mode always opens with the write header
    if (cfg_ten_bit) begin
      return ten_bit_header(1'b0);
    end
    return {cfg_addr[6:0], rw};
  endfunction

  function automatic result_t predict_sequencer(item_t it);
    result_t r;
    logic [15:0] f;
    r = '0;
    r.fault_code = ERR_NONE;
    f = it.event_flags;
    case (opcode_t'(it.opcode))
      OP_START_WR, OP_START_RD: begin
        if (seq_mode != MODE_IDLE) begin
          r.rejected = 1'b1;
        end else begin
          en_lvl = 1'b1;
          r.start_req = 1'b1;
          bytes_left = it.byte_count;
          restarted = 1'b0;
          if (opcode_t'(it.opcode) == OP_START_WR) begin
            seq_mode = MODE_TX;
          end else begin
            seq_mode = MODE_RX;
            ack_lvl = 1'b1;
          end
        end
      end
      OP_BUS_EVT: begin
        if (seq_mode == MODE_TX) begin
          if (f[FLAG_START]) begin
            r.dr_write = 1'b1;
            r.dr_value = leading_address(1'b0);
          end else if (f[FLAG_HEADER]) begin
            r.dr_write = 1'b1;
            r.dr_value = cfg_addr[7:0];
          end else if (f[FLAG_ADDR]) begin
            // address phase done, nothing to load
          end else if (f[FLAG_TX_EMPTY]) begin
            if (bytes_left == 8'd0) begin
              r.stop_req = 1'b1;
              en_lvl = 1'b0;
              seq_mode = MODE_IDLE;
            end else begin
              bytes_left = bytes_left - 8'd1;
              r.dr_write = 1'b1;
              r.dr_value = it.tx_byte;
              r.tx_taken = 1'b1;
            end
          end
        end else if (seq_mode == MODE_RX) begin
          if (f[FLAG_START]) begin
            r.dr_write = 1'b1;
            r.dr_value = restarted ? ten_bit_header(1'b1) : leading_address(1'b1);
          end else if (f[FLAG_HEADER]) begin
            r.dr_write = 1'b1;
            r.dr_value = cfg_addr[7:0];
          end else if (f[FLAG_ADDR]) begin
            if (!restarted && cfg_ten_bit) begin
              r.start_req = 1'b1;
              restarted = 1'b1;
            end else if (bytes_left == 8'd1) begin
              ack_lvl = 1'b0;
            end
          end else if (f[FLAG_RX_FULL]) begin
            r.rx_valid = 1'b1;
            r.rx_data = it.rx_byte;
            bytes_left = bytes_left - 8'd1;
            if (bytes_left < 8'd2) begin
              ack_lvl = 1'b0;
              r.stop_req = 1'b1;
              restarted = 1'b0;
              seq_mode = MODE_IDLE;
              en_lvl = 1'b0;
            end
          end
        end
      end
      default: begin
        if (f[FLAG_BUS_ERR]) begin
          r.fault_code = ERR_BUS;
        end else if (f[FLAG_ACK_FAIL]) begin
          r.fault_code = ERR_ACK_FAIL;
        end else if (f[FLAG_OVERRUN]) begin
          r.fault_code = ERR_OVERRUN;
        end else if (f[FLAG_TIMEOUT]) begin
          r.fault_code = ERR_TIMEOUT;
        end
        en_lvl = 1'b0;
        seq_mode = MODE_IDLE;
        restarted = 1'b0;
      end
    endcase
    r.ack_enable = ack_lvl;
    r.bus_enable = en_lvl;
    r.mode_now = seq_mode;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------
  task automatic report_mismatch(string field, logic [15:0] got, logic [15:0] want);
    $display("MISMATCH result %0d %s: got 0x%0h expected 0x%0h", results_seen, field,
             got, want);
    error_count++;
  endtask

  task automatic compare_result(result_t got, result_t want);
    if (got.rejected !== want.rejected) report_mismatch("rejected", got.rejected, want.rejected);
    if (got.dr_write !== want.dr_write) report_mismatch("dr_write", got.dr_write, want.dr_write);
    if (got.dr_value !== want.dr_value) report_mismatch("dr_value", got.dr_value, want.dr_value);
    if (got.start_req !== want.start_req) begin
      report_mismatch("start_req", got.start_req, want.start_req);
    end
    if (got.stop_req !== want.stop_req) report_mismatch("stop_req", got.stop_req, want.stop_req);
    if (got.ack_enable !== want.ack_enable) begin
      report_mismatch("ack_enable", got.ack_enable, want.ack_enable);
    end
    if (got.bus_enable !== want.bus_enable) begin
      report_mismatch("bus_enable", got.bus_enable, want.bus_enable);
    end
    if (got.tx_taken !== want.tx_taken) report_mismatch("tx_taken", got.tx_taken, want.tx_taken);
    if (got.rx_valid !== want.rx_valid) report_mismatch("rx_valid", got.rx_valid, want.rx_valid);
    if (got.rx_data !== want.rx_data) report_mismatch("rx_data", got.rx_data, want.rx_data);
    if (got.mode_now !== want.mode_now) report_mismatch("mode_now", got.mode_now, want.mode_now);
    if (got.fault_code !== want.fault_code) begin
      report_mismatch("fault_code", got.fault_code, want.fault_code);
    end
  endtask

  always @(posedge clk) begin : monitor
    item_t   seen;
    result_t got;
    result_t want;
    if (!rst) begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        if (cfg_ch.index == REG_TEN_BIT) begin
          cfg_ten_bit = cfg_ch.data[0];
        end else begin
          cfg_addr = cfg_ch.data;
        end
      end
      if (item_ch.valid && item_ch.ready) begin
        seen.opcode = item_ch.opcode;
        seen.byte_count = item_ch.byte_count;
        seen.event_flags = item_ch.event_flags;
        seen.tx_byte = item_ch.tx_byte;
        seen.rx_byte = item_ch.rx_byte;
        want = predict_sequencer(seen);
        n_rejected += want.rejected;
        n_tx_bytes += want.tx_taken;
        n_rx_bytes += want.rx_valid;
        n_stops += want.stop_req;
        if (want.fault_code != ERR_NONE) n_err_events++;
        pending_results.push_back(want);
      end
      if (res_ch.valid && res_ch.ready) begin
        got.rejected = res_ch.rejected;
        got.dr_write = res_ch.dr_write;
        got.dr_value = res_ch.dr_value;
        got.start_req = res_ch.start_req;
        got.stop_req = res_ch.stop_req;
        got.ack_enable = res_ch.ack_enable;
        got.bus_enable = res_ch.bus_enable;
        got.tx_taken = res_ch.tx_taken;
        got.rx_valid = res_ch.rx_valid;
        got.rx_data = res_ch.rx_data;
        got.mode_now = res_ch.mode_now;
        got.fault_code = res_ch.fault_code;
        if (pending_results.size() == 0) begin
          $display("MISMATCH result %0d arrived with nothing outstanding", results_seen);
          error_count++;
        end else begin
          want = pending_results.pop_front();
          compare_result(got, want);
        end
        results_seen++;
      end
    end
  end

  // receiver backpressure; the style is redrawn whenever its random hold count runs out
  always @(negedge clk) begin
    if (stall_left == 0) begin
      stall_style = $urandom_range(STALL_NONE, STALL_HEAVY);
      stall_left = $urandom_range(40, 300);
    end else begin
      stall_left--;
    end
    stall_phase = (stall_phase + 1) % 7;
    case (stall_style)
      STALL_NONE:     res_ch.ready = 1'b1;
      STALL_RANDOM:   res_ch.ready = 1'($urandom_range(0, 1));
      STALL_PERIODIC: res_ch.ready = (stall_phase < 4);
      default:        res_ch.ready = ($urandom_range(0, 3) == 0);
    endcase
  end

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------
  task automatic send_item(opcode_t op, logic [7:0] cnt, logic [15:0] flags,
                           logic [7:0] txb, logic [7:0] rxb);
    int gap;
    if (gaps_enabled && burst_left <= 0) begin
      gap = ($urandom_range(0, 7) == 0) ? $urandom_range(5, 20) : $urandom_range(0, 3);
      repeat (gap) begin
        @(negedge clk);
        item_ch.valid = 1'b0;
      end
      burst_left = $urandom_range(1, 12);
    end
    @(negedge clk);
    item_ch.valid = 1'b1;
    item_ch.opcode = op;
    item_ch.byte_count = cnt;
    item_ch.event_flags = flags;
    item_ch.tx_byte = txb;
    item_ch.rx_byte = rxb;
    burst_left--;
    items_sent++;
    @(posedge clk);
    while (!item_ch.ready) @(posedge clk);
  endtask

  task automatic send_start(opcode_t op, logic [7:0] cnt);
    send_item(op, cnt, 16'($urandom), 8'($urandom), 8'($urandom));
  endtask

  // one flag acted on; extra flags only where they cannot win the priority
  task automatic send_bus_event(int flag_bit, logic [15:0] masked);
    logic [15:0] flags;
    flags = 16'd1 << flag_bit;
    if ($urandom_range(0, 1)) flags |= 16'($urandom) & ~masked;
    send_item(OP_BUS_EVT, 8'($urandom), flags, 8'($urandom), 8'($urandom));
  endtask

  task automatic send_noise();
    send_item(opcode_t'($urandom_range(0, 3)), 8'($urandom), 16'($urandom), 8'($urandom),
              8'($urandom));
  endtask

  task automatic wait_until_drained();
    @(negedge clk);
    item_ch.valid = 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    // allow the pipeline to settle
    repeat (3) @(negedge clk);
  endtask

  task automatic write_reg(logic idx, logic [9:0] val);
    @(negedge clk);
    cfg_ch.valid = 1'b1;
    cfg_ch.index = idx;
    cfg_ch.data = val;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    @(negedge clk);
    cfg_ch.valid = 1'b0;
  endtask

  task automatic set_addressing(logic ten_bit, logic [9:0] addr);
    wait_until_drained();
    write_reg(REG_TEN_BIT, {9'd0, ten_bit});
    write_reg(REG_TARGET_ADDR, addr);
    stim_ten_bit = ten_bit;
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  task automatic test_directed_cases();
    set_addressing(1'b0, 10'h3FF);
    send_item(OP_BUS_EVT, 8'hFF, 16'hFFFF, 8'hFF, 8'hFF);          // ignored while idle
    send_start(OP_START_WR, 8'd0);
    send_start(OP_START_RD, 8'd255);                              // busy, rejected
    send_item(OP_BUS_EVT, 8'd0, 16'h0081, 8'h00, 8'h00);          // start wins over tx empty
    send_item(OP_BUS_EVT, 8'd0, 16'h0002, 8'h00, 8'h00);
    send_item(OP_BUS_EVT, 8'd0, 16'h0080, 8'hFF, 8'h00);          // nothing left: stop
    send_start(OP_START_WR, 8'd1);
    send_item(OP_BUS_EVT, 8'd0, 16'h0080, 8'hA5, 8'h00);
    send_item(OP_BUS_EVT, 8'd0, 16'h0080, 8'h5A, 8'h00);
    send_start(OP_START_RD, 8'd0);
    send_item(OP_BUS_EVT, 8'd0, 16'h0001, 8'h00, 8'h00);
    send_item(OP_BUS_EVT, 8'd0, 16'h0002, 8'h00, 8'h00);
    send_item(OP_BUS_EVT, 8'd0, 16'h0040, 8'h00, 8'hFF);          // count wraps to 255
    send_item(OP_BUS_EVT, 8'd0, 16'h0040, 8'h00, 8'h00);
    send_item(OP_ERR_EVT, 8'd0, 16'h0000, 8'h00, 8'h00);          // no known error flag
    send_item(OP_ERR_EVT, 8'd0, 16'hFFFF, 8'h00, 8'h00);
    send_item(OP_ERR_EVT, 8'd0, 16'h4C00, 8'h00, 8'h00);
    send_item(OP_ERR_EVT, 8'd0, 16'h4800, 8'h00, 8'h00);
    send_item(OP_ERR_EVT, 8'd0, 16'h4000, 8'h00, 8'h00);
    // 10-bit read with repeated start
    set_addressing(1'b1, 10'h2C5);
    send_start(OP_START_RD, 8'd2);
    send_item(OP_BUS_EVT, 8'd0, 16'h0001, 8'h00, 8'h00);
    send_item(OP_BUS_EVT, 8'd0, 16'h0008, 8'h00, 8'h00);
    send_item(OP_BUS_EVT, 8'd0, 16'h0002, 8'h00, 8'h00);
    send_item(OP_BUS_EVT, 8'd0, 16'h0001, 8'h00, 8'h00);
    send_item(OP_BUS_EVT, 8'd0, 16'h0002, 8'h00, 8'h00);
    send_item(OP_BUS_EVT, 8'd0, 16'h0040, 8'h00, 8'h3C);
  endtask

  // one bus transaction as the peripheral would report it, with occasional noise
  task automatic run_transaction();
    logic       is_read;
    logic [7:0] cnt;
    int         n_data;
    logic [15:0] data_mask;
    is_read = 1'($urandom_range(0, 1));
    if ($urandom_range(0, 19) == 0) begin
      cnt = 8'($urandom);
    end else begin
      cnt = is_read ? 8'($urandom_range(1, 5)) : 8'($urandom_range(0, 5));
    end
    send_start(is_read ? OP_START_RD : OP_START_WR, cnt);
    if ($urandom_range(0, 24) == 0) send_noise();
    send_bus_event(FLAG_START, 16'h0000);
    if (stim_ten_bit) send_bus_event(FLAG_HEADER, 16'h0001);
    send_bus_event(FLAG_ADDR, 16'h0009);
    if (is_read && stim_ten_bit) begin
      send_bus_event(FLAG_START, 16'h0000);
      send_bus_event(FLAG_ADDR, 16'h0009);
    end
    if ($urandom_range(0, 39) == 0) begin
      send_item(OP_ERR_EVT, 8'($urandom), 16'($urandom), 8'($urandom), 8'($urandom));
      return;
    end
    if (is_read) begin
      n_data = (cnt >= 2) ? cnt - 1 : ((cnt == 1) ? 1 : 255);
    end else begin
      n_data = cnt + 1;
    end
    data_mask = 16'h000B;
    for (int i = 0; i < n_data; i++) begin
      send_bus_event(is_read ? FLAG_RX_FULL : FLAG_TX_EMPTY, data_mask);
      if ($urandom_range(0, 29) == 0) send_noise();
    end
  endtask

  task automatic test_random_traffic(int n_phases, int items_per_phase);
    int   phase_start;
    logic paused;
    for (int p = 0; p < n_phases; p++) begin
      case (p)
        0:       set_addressing(1'b0, 10'h000);
        1:       set_addressing(1'b1, 10'h3FF);
        2:       set_addressing(1'b1, 10'h000);
        3:       set_addressing(1'b0, 10'h3FF);
        default: set_addressing(1'($urandom), 10'($urandom));
      endcase
      phase_start = items_sent;
      paused = 1'b0;
      while (items_sent - phase_start < items_per_phase) begin
        run_transaction();
        // sender holds off until everything outstanding has come back
        if (!paused && items_sent - phase_start > items_per_phase / 2) begin
          wait_until_drained();
          paused = 1'b1;
        end
      end
    end
  endtask

  task automatic test_back_to_back(int n_items);
    int phase_start;
    gaps_enabled = 1'b0;
    set_addressing(1'b1, 10'($urandom));
    phase_start = items_sent;
    while (items_sent - phase_start < n_items) run_transaction();
    gaps_enabled = 1'b1;
  endtask

  initial begin
    rst = 1'b1;
    item_ch.valid = 1'b0;
    item_ch.opcode = OP_START_WR;
    item_ch.byte_count = '0;
    item_ch.event_flags = '0;
    item_ch.tx_byte = '0;
    item_ch.rx_byte = '0;
    res_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = REG_TEN_BIT;
    cfg_ch.data = '0;
    seq_mode = MODE_IDLE;
    bytes_left = '0;
    restarted = 1'b0;
    ack_lvl = 1'b0;
    en_lvl = 1'b0;
    cfg_ten_bit = 1'b0;
    cfg_addr = '0;
    stim_ten_bit = 1'b0;
    gaps_enabled = 1'b1;
    burst_left = 0;
    stall_style = STALL_NONE;
    stall_left = 0;
    stall_phase = 0;
    error_count = 0;
    results_seen = 0;
    items_sent = 0;
    n_rejected = 0;
    n_tx_bytes = 0;
    n_rx_bytes = 0;
    n_err_events = 0;
    n_stops = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_directed_cases();
    test_random_traffic(8, 100);
    test_back_to_back(100);
    wait_until_drained();

    $display("Run: %0d items, %0d results checked, %0d starts refused, %0d error events",
             items_sent, results_seen, n_rejected, n_err_events);
    $display("     %0d bytes sent, %0d bytes received, %0d stops, 7-bit and 10-bit addressing",
             n_tx_bytes, n_rx_bytes, n_stops);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/i2cms_pkg.sv
hw/rtl/i2cms_if.sv
hw/rtl/i2cms_cfg_regs.sv
hw/rtl/i2cms_seq_core.sv
hw/rtl/i2c_master_event_sequencer.sv
verif/tb.sv
